// File: rtl/qmsd_pkg.sv
// ----------------------------------------------------------------------------
// qmsd_pkg
// Shared types and constants for the quantized mesh stream decoder.
// ----------------------------------------------------------------------------
package qmsd_pkg;

  localparam int unsigned HeaderBytes = 92;
  localparam int unsigned VcountOfs   = 88;
  localparam logic [31:0] WideLimit   = 32'd65536;
  localparam int unsigned PadBytes    = 2;

  localparam logic [2:0] KIND_U      = 3'd0;
  localparam logic [2:0] KIND_V      = 3'd1;
  localparam logic [2:0] KIND_H      = 3'd2;
  localparam logic [2:0] KIND_INDEX  = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_TRUNC = 1'b1;

  typedef enum logic [7:0] {
    PH_HDR  = 8'b0000_0001,
    PH_U    = 8'b0000_0010,
    PH_V    = 8'b0000_0100,
    PH_H    = 8'b0000_1000,
    PH_PAD  = 8'b0001_0000,
    PH_TCNT = 8'b0010_0000,
    PH_IDX  = 8'b0100_0000,
    PH_DONE = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [6:0]  cnt;    // byte position in header, word or triangle
    logic [31:0] vtotal;
    logic [31:0] left;   // words left in channel, or triangles left
    logic [23:0] wasm;
    logic [31:0] csum;
    logic [31:0] hwm;
    logic        wide;
    logic [1:0]  ofs;    // bytes consumed mod 4
  } state_t;

  localparam state_t StateReset = '{
    phase:  PH_HDR,
    cnt:    '0,
    vtotal: '0,
    left:   '0,
    wasm:   '0,
    csum:   '0,
    hwm:    '0,
    wide:   1'b0,
    ofs:    '0
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] coord;
    logic [31:0] idx;
    logic        stat;
    logic        done;
  } result_t;

endpackage

// File: rtl/qmsd_step.sv
// ----------------------------------------------------------------------------
// qmsd_step
// Next-state and result logic for one stream byte.
// ----------------------------------------------------------------------------
module qmsd_step (
  input  qmsd_pkg::state_t  st_i,
  input  logic [7:0]        byte_i,
  input  logic              eod_i,
  output qmsd_pkg::state_t  st_o,
  output logic              res_valid_o,
  output qmsd_pkg::result_t res_o
);

  qmsd_pkg::state_t  nx;
  qmsd_pkg::result_t res;
  logic              rv;
  logic [15:0]       word;
  logic [31:0]       zz;
  logic [31:0]       csum_nx;
  logic [31:0]       left_nx;
  logic [31:0]       vt_nx;
  logic [31:0]       code;
  logic [31:0]       idx_raw;
  logic [31:0]       hwm_inc;
  logic [1:0]        pos;
  logic              last_byte;
  logic [6:0]        cnt_inc;
  logic [6:0]        tri_bytes;
  logic [23:0]       byte_sh;

  always_comb begin
    nx   = st_i;
    res  = '0;
    rv   = 1'b0;
    nx.ofs = st_i.ofs + 2'd1;

    cnt_inc   = st_i.cnt + 7'd1;
    word      = {byte_i, st_i.wasm[7:0]};
    zz        = {17'd0, word[15:1]} ^ {32{word[0]}};
    csum_nx   = st_i.csum + zz;
    left_nx   = st_i.left - 32'd1;
    vt_nx     = st_i.vtotal | ({24'd0, byte_i} << {st_i.cnt[1:0], 3'd0});
    pos       = st_i.cnt[1:0] & (st_i.wide ? 2'd3 : 2'd1);
    last_byte = st_i.wide ? (pos == 2'd3) : (pos == 2'd1);
    byte_sh   = {16'd0, byte_i} << {pos, 3'd0};
    code      = st_i.wide ? {byte_i, st_i.wasm} : {16'd0, byte_i, st_i.wasm[7:0]};
    idx_raw   = st_i.hwm - code;
    hwm_inc   = st_i.hwm + 32'd1;
    tri_bytes = st_i.wide ? 7'd12 : 7'd6;

    case (st_i.phase)
      qmsd_pkg::PH_HDR: begin
        if (st_i.cnt >= 7'(qmsd_pkg::VcountOfs)) begin
          nx.vtotal = vt_nx;
        end
        nx.cnt = cnt_inc;
        if (cnt_inc >= 7'(qmsd_pkg::HeaderBytes)) begin
          nx.wide = (nx.vtotal > qmsd_pkg::WideLimit);
          nx.cnt  = '0;
          nx.wasm = '0;
          if (nx.vtotal == 32'd0) begin
            nx.phase = (nx.wide && nx.ofs != 2'd0) ? qmsd_pkg::PH_PAD
                                                   : qmsd_pkg::PH_TCNT;
          end else begin
            nx.phase = qmsd_pkg::PH_U;
            nx.left  = nx.vtotal;
            nx.csum  = '0;
          end
        end
      end
      qmsd_pkg::PH_U, qmsd_pkg::PH_V, qmsd_pkg::PH_H: begin
        if (st_i.cnt == 7'd0) begin
          nx.wasm = {16'd0, byte_i};
          nx.cnt  = 7'd1;
        end else begin
          rv        = 1'b1;
          res.coord = csum_nx;
          nx.csum   = csum_nx;
          nx.cnt    = '0;
          nx.wasm   = '0;
          nx.left   = left_nx;
          case (st_i.phase)
            qmsd_pkg::PH_U: res.kind = qmsd_pkg::KIND_U;
            qmsd_pkg::PH_V: res.kind = qmsd_pkg::KIND_V;
            default:        res.kind = qmsd_pkg::KIND_H;
          endcase
          if (left_nx == 32'd0) begin
            case (st_i.phase)
              qmsd_pkg::PH_U: begin
                nx.phase = qmsd_pkg::PH_V;
                nx.left  = st_i.vtotal;
                nx.csum  = '0;
              end
              qmsd_pkg::PH_V: begin
                nx.phase = qmsd_pkg::PH_H;
                nx.left  = st_i.vtotal;
                nx.csum  = '0;
              end
              default: begin
                nx.phase = (st_i.wide && nx.ofs != 2'd0) ? qmsd_pkg::PH_PAD
                                                         : qmsd_pkg::PH_TCNT;
              end
            endcase
          end
        end
      end
      qmsd_pkg::PH_PAD: begin
        nx.cnt = cnt_inc;
        if (cnt_inc >= 7'(qmsd_pkg::PadBytes)) begin
          nx.phase = qmsd_pkg::PH_TCNT;
          nx.cnt   = '0;
          nx.wasm  = '0;
        end
      end
      qmsd_pkg::PH_TCNT: begin
        if (st_i.cnt < 7'd3) begin
          nx.wasm = st_i.wasm | ({16'd0, byte_i} << {st_i.cnt[1:0], 3'd0});
          nx.cnt  = cnt_inc;
        end else begin
          nx.cnt  = '0;
          nx.wasm = '0;
          if ({byte_i, st_i.wasm} == 32'd0) begin
            nx.phase = qmsd_pkg::PH_DONE;
            rv       = 1'b1;
            res.kind = qmsd_pkg::KIND_STATUS;
            res.done = 1'b1;
          end else begin
            nx.left  = {byte_i, st_i.wasm};
            nx.hwm   = '0;
            nx.phase = qmsd_pkg::PH_IDX;
          end
        end
      end
      qmsd_pkg::PH_IDX: begin
        nx.cnt = cnt_inc;
        if (!last_byte) begin
          nx.wasm = st_i.wasm | byte_sh;
        end else begin
          rv       = 1'b1;
          res.kind = qmsd_pkg::KIND_INDEX;
          res.idx  = st_i.wide ? idx_raw : {16'd0, idx_raw[15:0]};
          if (code == 32'd0) begin
            nx.hwm = st_i.wide ? hwm_inc : {16'd0, hwm_inc[15:0]};
          end
          nx.wasm = '0;
          if (cnt_inc >= tri_bytes) begin
            nx.cnt  = '0;
            nx.left = left_nx;
            if (left_nx == 32'd0) begin
              nx.phase = qmsd_pkg::PH_DONE;
              res.done = 1'b1;
            end
          end
        end
      end
      default: begin
        // drop bytes after completion
      end
    endcase

    if (eod_i) begin
      if (nx.phase != qmsd_pkg::PH_DONE) begin
        rv       = 1'b1;
        res.kind = qmsd_pkg::KIND_STATUS;
        res.coord = '0;
        res.idx  = '0;
        res.stat = qmsd_pkg::STAT_TRUNC;
        res.done = 1'b1;
      end
      nx = qmsd_pkg::StateReset;
    end
  end

  assign st_o        = nx;
  assign res_valid_o = rv;
  assign res_o       = res;

endmodule

// File: rtl/quantized_mesh_stream_decoder.sv
// ----------------------------------------------------------------------------
// quantized_mesh_stream_decoder
// Byte-serial decoder for quantized-mesh terrain tiles: vertex channels with
// zigzag delta decoding and high-water-mark triangle indices.
// ----------------------------------------------------------------------------
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_byte_i,       | consumer
//           | end_of_data_i                            |
//   out     | out_valid_o, out_ready_i, item_kind_o,   | producer
//           | coord_value_o, index_value_o, status_o,  |
//           | mesh_done_o                              |
//
// One byte is taken per cycle while in_ready_o is high; its result, if any,
// shows on the output register in the cycle after the byte is taken.
// The decode state, the result register and its valid flag are the only storage.
// in_ready_o is high while the result register is empty or being drained,
// so a waiting result stalls the input only when out_ready_i is low.
// Reset returns the decoder to the header phase with no result pending.
// ----------------------------------------------------------------------------
module quantized_mesh_stream_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         item_kind_o,
  output logic signed [31:0] coord_value_o,
  output logic [31:0]        index_value_o,
  output logic               status_o,
  output logic               mesh_done_o
);

  qmsd_pkg::state_t  state_q, state_d;
  qmsd_pkg::result_t res_q, step_res;
  logic              step_rv;
  logic              out_valid_q, out_valid_d;
  logic              in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  qmsd_step u_step (
    .st_i        (state_q),
    .byte_i      (in_byte_i),
    .eod_i       (end_of_data_i),
    .st_o        (state_d),
    .res_valid_o (step_rv),
    .res_o       (step_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = step_rv;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qmsd_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && step_rv) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign item_kind_o   = res_q.kind;
  assign coord_value_o = res_q.coord;
  assign index_value_o = res_q.idx;
  assign status_o      = res_q.stat;
  assign mesh_done_o   = res_q.done;

  a_trunc_is_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> mesh_done_o && item_kind_o == qmsd_pkg::KIND_STATUS)
    else $error("truncation status without final status item");

  a_eod_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_data_i |=> state_q.phase == qmsd_pkg::PH_HDR && state_q.cnt == 7'd0)
    else $error("decoder not back in header phase after end of data");

  a_index_no_coord : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == qmsd_pkg::KIND_INDEX |-> coord_value_o == 32'sd0)
    else $error("index item carries a coordinate");

  a_short_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == qmsd_pkg::PH_IDX && !state_q.wide |-> state_q.hwm[31:16] == 16'd0)
    else $error("short index mark exceeds 16 bits");

endmodule
